// ----- hdl/ghsc_pkg.sv -----
// Shared types, constants and tables for the go-to-heading speed controller.
// Used by every module of the block; no dependencies.
`default_nettype none
package ghsc_pkg;

    localparam int IN_W   = 192;
    localparam int OUT_W  = 136;
    localparam int CFG_W  = 31;
    localparam int CIN_W  = 36;
    localparam int CORD_W = 46;

    localparam logic [1:0] REG_STOP_RANGE = 2'd0;
    localparam logic [1:0] REG_FAR_SPEED  = 2'd1;
    localparam logic [1:0] REG_ANGLE_TOL  = 2'd2;
    localparam logic [1:0] REG_DIST_TOL   = 2'd3;

    localparam logic [30:0] RST_STOP_RANGE = 31'd0;
    localparam logic [30:0] RST_FAR_SPEED  = 31'd196608;
    localparam logic [17:0] RST_ANGLE_TOL  = 18'd7864;
    localparam logic [30:0] RST_DIST_TOL   = 31'd72090;

    localparam logic signed [33:0] FX_PI         = 34'sd205887;
    localparam logic signed [33:0] FX_HALF_PI    = 34'sd102944;
    localparam logic signed [33:0] FX_THREE      = 34'sd196608;
    localparam logic signed [35:0] FX_FIVE       = 36'sd327680;
    localparam logic signed [35:0] FX_ONE        = 36'sd65536;
    localparam logic [34:0]        FX_FIFTEEN    = 35'd983040;
    localparam logic signed [33:0] FX_FAR_SPD    = 34'sd13107;
    localparam logic signed [33:0] FX_SPEED_STEP = 34'sd1311;
    localparam logic signed [33:0] FX_TURN_STEP  = 34'sd6554;
    localparam logic signed [33:0] FX_DECAY_BAND = 34'sd1966;
    localparam logic signed [33:0] FX_DECAY_EDGE = 34'sd1311;
    localparam logic signed [33:0] FX_DECAY_STEP = 34'sd655;
    localparam logic [25:0]        DIV100_MUL    = 26'd42949673;

    localparam logic [4:0] CORDIC_LAST = 5'd16;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [2:0] mul_idx;
        logic       cordic_start;
        logic       root_en;
        logic       stage_a;
        logic       commit;
    } ghsc_cmd_t;

    typedef struct packed {
        logic cordic_done;
    } ghsc_status_t;

    function automatic logic [16:0] atan_entry(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd51472;
            5'd1:    r = 17'd30386;
            5'd2:    r = 17'd16055;
            5'd3:    r = 17'd8150;
            5'd4:    r = 17'd4091;
            5'd5:    r = 17'd2047;
            5'd6:    r = 17'd1024;
            5'd7:    r = 17'd512;
            5'd8:    r = 17'd256;
            5'd9:    r = 17'd128;
            5'd10:   r = 17'd64;
            5'd11:   r = 17'd32;
            5'd12:   r = 17'd16;
            5'd13:   r = 17'd8;
            5'd14:   r = 17'd4;
            5'd15:   r = 17'd2;
            5'd16:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647)       r = 32'h7FFF_FFFF;
        else if (v < -36'sd2147483648) r = 32'h8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/ghsc_cordic.sv -----
// Iterative vectoring CORDIC arctangent, one rotation per cycle.
// Depends on ghsc_pkg.
`default_nettype none
module ghsc_cordic (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic signed [ghsc_pkg::CIN_W-1:0] y_in,
    input  wire logic signed [ghsc_pkg::CIN_W-1:0] x_in,
    output logic                             done,
    output logic signed [31:0]               angle
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_ITER = 2'd2;
    localparam int W = ghsc_pkg::CORD_W;

    logic [1:0]             phase_reg, phase_next;
    logic                   done_reg, done_next;
    logic signed [W-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [31:0]     z_reg, z_next, base_reg, base_next;
    logic [4:0]             i_reg, i_next;
    logic signed [W-1:0]    xe, ye, xs, ys;
    logic [W-1:0]           ax, ay, mag;
    logic signed [31:0]     step;

    always_comb begin
        xe = {{(W-ghsc_pkg::CIN_W){x_in[ghsc_pkg::CIN_W-1]}}, x_in};
        ye = {{(W-ghsc_pkg::CIN_W){y_in[ghsc_pkg::CIN_W-1]}}, y_in};
        ax = x_reg[W-1] ? W'(-x_reg) : W'(x_reg);
        ay = y_reg[W-1] ? W'(-y_reg) : W'(y_reg);
        mag = ax | ay;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        step = {15'd0, ghsc_pkg::atan_entry(i_reg)};
        phase_next = phase_reg;
        done_next = done_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        base_next = base_reg;
        i_next = i_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    z_next = '0;
                    i_next = '0;
                    if (x_in == '0 && y_in == '0) begin
                        base_next = '0;
                        done_next = 1'b1;
                    end else begin
                        done_next = 1'b0;
                        phase_next = PH_NORM;
                        if (x_in < 0) begin
                            x_next = -xe;
                            y_next = -ye;
                            base_next = (y_in >= 0) ? 32'(ghsc_pkg::FX_PI)
                                                    : 32'(-ghsc_pkg::FX_PI);
                        end else begin
                            x_next = xe;
                            y_next = ye;
                            base_next = '0;
                        end
                    end
                end
            end
            PH_NORM: begin
                if (mag[W-1:32] == '0) begin
                    x_next = x_reg <<< 8;
                    y_next = y_reg <<< 8;
                end else if (mag[W-1:36] == '0) begin
                    x_next = x_reg <<< 4;
                    y_next = y_reg <<< 4;
                end else if (mag[W-1:38] == '0) begin
                    x_next = x_reg <<< 2;
                    y_next = y_reg <<< 2;
                end else if (mag[W-1:40] == '0) begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end else begin
                    phase_next = PH_ITER;
                end
            end
            PH_ITER: begin
                if (y_reg > 0) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + step;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - step;
                end
                i_next = i_reg + 5'd1;
                if (i_reg == ghsc_pkg::CORDIC_LAST) begin
                    phase_next = PH_IDLE;
                    done_next = 1'b1;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        base_reg <= base_next;
        i_reg <= i_next;
    end

    assign done = done_reg && (phase_reg == PH_IDLE);
    assign angle = z_reg + base_reg;

endmodule
`default_nettype wire

// ----- hdl/ghsc_datapath.sv -----
// Datapath: config registers, squaring, square root, two CORDIC units,
// control-law evaluation, command state and output register. Uses ghsc_pkg, ghsc_cordic.
`default_nettype none
module ghsc_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ghsc_pkg::ghsc_cmd_t          cmd,
    output ghsc_pkg::ghsc_status_t            status,
    input  wire logic [ghsc_pkg::IN_W-1:0]    s_tdata,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_addr,
    input  wire logic [ghsc_pkg::CFG_W-1:0]   cfg_wdata,
    output logic [ghsc_pkg::OUT_W-1:0]        m_tdata
);
    logic [30:0] stop_range_reg, far_speed_reg, dist_tol_reg;
    logic [17:0] angle_tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_range_reg <= ghsc_pkg::RST_STOP_RANGE;
            far_speed_reg <= ghsc_pkg::RST_FAR_SPEED;
            angle_tol_reg <= ghsc_pkg::RST_ANGLE_TOL;
            dist_tol_reg <= ghsc_pkg::RST_DIST_TOL;
        end else if (cfg_we) begin
            case (cfg_addr)
                ghsc_pkg::REG_STOP_RANGE: stop_range_reg <= cfg_wdata;
                ghsc_pkg::REG_FAR_SPEED:  far_speed_reg <= cfg_wdata;
                ghsc_pkg::REG_ANGLE_TOL:  angle_tol_reg <= cfg_wdata[17:0];
                ghsc_pkg::REG_DIST_TOL:   dist_tol_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Load: differences and quaternion products
    logic signed [32:0] dx_reg, dz_reg;
    logic signed [31:0] pyw_reg, pxz_reg, pyy_reg, pzz_reg;
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] tx, tz, ox, oz;

    assign tx = s_tdata[31:0];
    assign tz = s_tdata[63:32];
    assign ox = s_tdata[95:64];
    assign oz = s_tdata[127:96];
    assign qw = s_tdata[143:128];
    assign qx = s_tdata[159:144];
    assign qy = s_tdata[175:160];
    assign qz = s_tdata[191:176];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dx_reg <= {tx[31], tx} - {ox[31], ox};
            dz_reg <= {tz[31], tz} - {oz[31], oz};
            pyw_reg <= qy * qw;
            pxz_reg <= qx * qz;
            pyy_reg <= qy * qy;
            pzz_reg <= qz * qz;
        end
    end

    // Sum of squares by 17x17 partial products
    logic [32:0] ux, uz, opv;
    logic [16:0] mul_a, mul_b;
    logic [33:0] prod;
    logic [65:0] term;
    logic [65:0] acc_reg;
    logic [5:0]  sh;

    assign ux = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign uz = dz_reg[32] ? 33'(-dz_reg) : 33'(dz_reg);

    always_comb begin
        opv = (cmd.mul_idx >= 3'd3) ? uz : ux;
        case (cmd.mul_idx)
            3'd0, 3'd3: begin mul_a = opv[16:0]; mul_b = opv[16:0]; sh = 6'd0; end
            3'd1, 3'd4: begin mul_a = opv[16:0]; mul_b = {1'b0, opv[32:17]}; sh = 6'd18; end
            3'd2, 3'd5: begin
                mul_a = {1'b0, opv[32:17]};
                mul_b = {1'b0, opv[32:17]};
                sh = 6'd34;
            end
            default: begin mul_a = '0; mul_b = '0; sh = 6'd0; end
        endcase
        prod = mul_a * mul_b;
        term = 66'(prod) << sh;
    end

    // Square root, one result bit per step
    logic [34:0] rem_reg;
    logic [32:0] root_reg;
    logic [36:0] rem_s, trial;
    logic        ge;

    always_comb begin
        rem_s = {rem_reg, acc_reg[65:64]};
        trial = {2'b00, root_reg, 2'b01};
        ge = rem_s >= trial;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg <= '0;
            rem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.mul_en) begin
            acc_reg <= acc_reg + term;
        end else if (cmd.root_en) begin
            acc_reg <= acc_reg << 2;
            rem_reg <= ge ? 35'(rem_s - trial) : rem_s[34:0];
            root_reg <= {root_reg[31:0], ge};
        end
    end

    // Heading and roll
    logic signed [35:0] num36, den36;
    logic               h_done, r_done;
    logic signed [31:0] heading, roll;

    always_comb begin
        num36 = ({{4{pyw_reg[31]}}, pyw_reg} - {{4{pxz_reg[31]}}, pxz_reg}) <<< 1;
        den36 = 36'sd268435456 - ({{4{pyy_reg[31]}}, pyy_reg} <<< 1)
                               - ({{4{pzz_reg[31]}}, pzz_reg} <<< 1);
    end

    ghsc_cordic u_heading (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.cordic_start),
        .y_in({{3{dx_reg[32]}}, dx_reg}), .x_in({{3{dz_reg[32]}}, dz_reg}),
        .done(h_done), .angle(heading)
    );

    ghsc_cordic u_roll (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.cordic_start),
        .y_in(num36), .x_in(den36),
        .done(r_done), .angle(roll)
    );

    assign status.cordic_done = h_done && r_done;

    // First evaluation stage
    logic signed [35:0] d_c, d_reg;
    logic [34:0]        ad_c;
    logic               far_reg;
    logic [45:0]        spd_prod_reg;
    logic signed [33:0] hr_diff;
    logic [33:0]        trn_reg;

    always_comb begin
        d_c = $signed({3'b000, root_reg}) - $signed({5'b00000, stop_range_reg});
        ad_c = d_c[35] ? 35'(-d_c) : 35'(d_c);
        hr_diff = {{2{heading[31]}}, heading} - {{2{roll[31]}}, roll};
    end

    always_ff @(posedge aclk) begin
        if (cmd.stage_a) begin
            d_reg <= d_c;
            far_reg <= ad_c > ghsc_pkg::FX_FIFTEEN;
            spd_prod_reg <= ad_c[19:0] * ghsc_pkg::DIV100_MUL;
            trn_reg <= hr_diff[33] ? 34'(-hr_diff) : 34'(hr_diff);
        end
    end

    // Second stage: slew, decide, commit
    logic signed [31:0] speed_reg, turn_reg, last_reg;
    logic signed [33:0] spd, trn, sp_cur, tr_cur, lst, c;
    logic signed [33:0] spd_new, trn_new, hd, rl, err, atol, v, half;
    logic signed [35:0] dtol, lin, ang, lw, rw;
    logic signed [31:0] speed_next, turn_next, last_next;
    logic               aligned, arr, right;

    always_comb begin
        spd = far_reg ? ghsc_pkg::FX_FAR_SPD : $signed({20'd0, spd_prod_reg[45:32]});
        trn = $signed(trn_reg);
        sp_cur = {{2{speed_reg[31]}}, speed_reg};
        tr_cur = {{2{turn_reg[31]}}, turn_reg};
        lst = {{2{last_reg[31]}}, last_reg};
        spd_new = sp_cur;
        if (spd > sp_cur) begin
            c = sp_cur + ghsc_pkg::FX_SPEED_STEP;
            spd_new = (spd < c) ? spd : c;
        end else if (spd < sp_cur) begin
            c = sp_cur - ghsc_pkg::FX_SPEED_STEP;
            spd_new = (spd > c) ? spd : c;
        end else begin
            c = sp_cur;
        end
        trn_new = tr_cur;
        if (trn > tr_cur) begin
            trn_new = (trn < tr_cur + ghsc_pkg::FX_TURN_STEP) ? trn
                      : tr_cur + ghsc_pkg::FX_TURN_STEP;
        end else if (trn < tr_cur) begin
            trn_new = (trn > tr_cur - ghsc_pkg::FX_TURN_STEP) ? trn
                      : tr_cur - ghsc_pkg::FX_TURN_STEP;
        end
        trn_new = $signed({{2{1'b0}}, ghsc_pkg::sat32(36'(trn_new))});
        trn_new = {{2{trn_new[31]}}, trn_new[31:0]};
        hd = {{2{heading[31]}}, heading};
        if (hd > ghsc_pkg::FX_THREE || hd < -ghsc_pkg::FX_THREE) hd = ghsc_pkg::FX_PI;
        rl = {{2{roll[31]}}, roll};
        err = hd - rl;
        atol = $signed({16'd0, angle_tol_reg});
        dtol = $signed({5'd0, dist_tol_reg});
        aligned = (err > -atol) && (err < atol);
        arr = 1'b0;
        lin = '0;
        ang = '0;
        lw = '0;
        rw = '0;
        v = lst;
        half = trn_new >>> 1;
        right = 1'b0;
        speed_next = spd_new[31:0];
        turn_next = trn_new[31:0];
        last_next = last_reg;
        if (aligned) begin
            if (d_reg < dtol && d_reg > -dtol) begin
                arr = 1'b1;
                speed_next = '0;
                turn_next = '0;
                last_next = '0;
            end else begin
                if (d_reg < ghsc_pkg::FX_FIVE) begin
                    if (d_reg > 0) begin
                        lw = ghsc_pkg::FX_ONE;
                        lin = 36'(spd_new);
                    end else begin
                        lw = -ghsc_pkg::FX_ONE;
                        lin = -36'(spd_new);
                    end
                end else begin
                    lw = $signed({5'd0, far_speed_reg});
                    lin = 36'(spd_new);
                end
                rw = lw;
                last_next = ghsc_pkg::sat32(lin);
            end
        end else begin
            if (v > ghsc_pkg::FX_DECAY_BAND || v < -ghsc_pkg::FX_DECAY_BAND) begin
                if (v > ghsc_pkg::FX_DECAY_EDGE) v = v - ghsc_pkg::FX_DECAY_STEP;
                else if (v < -ghsc_pkg::FX_DECAY_EDGE) v = v + ghsc_pkg::FX_DECAY_STEP;
            end else begin
                v = '0;
            end
            speed_next = v[31:0];
            last_next = v[31:0];
            lin = 36'(v);
            if (hd < -ghsc_pkg::FX_HALF_PI && rl > ghsc_pkg::FX_HALF_PI) right = 1'b0;
            else if (hd > ghsc_pkg::FX_HALF_PI && rl < -ghsc_pkg::FX_HALF_PI) right = 1'b1;
            else right = hd < rl;
            if (right) begin
                lw = 36'(half);
                rw = -36'(half);
                ang = -36'(trn_new);
            end else begin
                lw = -36'(half);
                rw = 36'(half);
                ang = 36'(trn_new);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= '0;
            turn_reg <= '0;
            last_reg <= '0;
        end else if (cmd.commit) begin
            speed_reg <= speed_next;
            turn_reg <= turn_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata <= {7'd0, arr, ghsc_pkg::sat32(rw), ghsc_pkg::sat32(lw),
                        ghsc_pkg::sat32(ang), ghsc_pkg::sat32(lin)};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ghsc_ctrl.sv -----
// Controller: sequences load, squaring, root, CORDIC wait, evaluation and
// output hand-off. Uses ghsc_pkg.
`default_nettype none
module ghsc_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire ghsc_pkg::ghsc_status_t status,
    output ghsc_pkg::ghsc_cmd_t         cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_EVA  = 3'd4;
    localparam logic [2:0] ST_EVB  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_idx = cnt_reg[2:0];
                cmd.cordic_start = (cnt_reg == 6'd0);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd5) begin
                    cnt_next = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_en = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd32) state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.cordic_done) state_next = ST_EVA;
            end
            ST_EVA: begin
                cmd.stage_a = 1'b1;
                state_next = ST_EVB;
            end
            ST_EVB: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_tvalid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid_reg && !m_tready)) else $error("result overwritten");
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg) else $error("result not presented");
    a_accept_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL && cnt_reg == 6'd0))
        else $error("request not started");
    a_eval_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.stage_a |-> status.cordic_done) else $error("angles not ready");

endmodule
`default_nettype wire

// ----- hdl/goto_heading_speed_controller_core.sv -----
// Go-to-heading speed controller: one control tick per request.
// Input request on s_t*, one result per request on m_t*; config by cfg_we/cfg_addr/cfg_wdata.
// Each request steps through load, squaring, root, a wait to pick up the CORDIC done,
// then the evaluation states ST_EVA and ST_EVB, which commit the result.
// The two CORDIC units run alongside the root and finish within it. One request is in
// work at a time: a new request is taken only after the last one has been committed.
// s_tready is high only while the block is idle. A finished result sits in the output
// register; if the receiver stalls, the next request is still accepted and computed,
// and waits in ST_EVB before commit until the output register is free.
// Synchronous active-low reset clears the command state (speed, turn, last linear),
// the output valid and restores the register defaults. Config writes take effect at
// once and are to be made while idle. Register indexes: 0 stop range, 1 far wheel
// speed, 2 angle tolerance, 3 distance tolerance.
// Depends on ghsc_pkg, ghsc_ctrl, ghsc_datapath, ghsc_cordic.
`default_nettype none
module goto_heading_speed_controller_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // target_x, target_z, own_x, own_z, quat_w, quat_x, quat_y, quat_z
    input  wire logic [ghsc_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // linear_velocity, angular_velocity, left_wheel, right_wheel, arrived, zero pad
    output logic [ghsc_pkg::OUT_W-1:0]      m_tdata,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_addr,
    input  wire logic [ghsc_pkg::CFG_W-1:0] cfg_wdata
);
    ghsc_pkg::ghsc_cmd_t    cmd;
    ghsc_pkg::ghsc_status_t status;

    ghsc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .status(status), .cmd(cmd)
    );

    ghsc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .s_tdata(s_tdata), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .m_tdata(m_tdata)
    );

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for goto_heading_speed_controller_core: drives control ticks,
// predicts each result from a behavioral copy of the controller, checks every field.
// Depends on ghsc_pkg and the core RTL.
`timescale 1ns / 100ps
module tb_top;
    import ghsc_pkg::*;

    typedef struct packed {
        logic [31:0] linear;
        logic [31:0] angular;
        logic [31:0] left_wh;
        logic [31:0] right_wh;
        logic        arrived;
    } cmd_result_t;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_we = 0;
    logic [1:0]          cfg_addr = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    goto_heading_speed_controller_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    logic [IN_W-1:0] tick_queue[$];
    cmd_result_t     cmd_expected[$];
    int              errors = 0;
    int              ticks_sent = 0;

    // controller model state
    longint stop_rng, far_spd, ang_tol, dist_tol;
    longint spd_cmd, trn_cmd, last_lin;

    localparam longint ATAN_LUT[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2, 1};

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint root66(logic [65:0] s);
        logic [67:0] rem, trial, root;
        rem = 0;
        root = 0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | s[2*i+1 -: 2];
            trial = (root << 2) | 68'd1;
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 68'd1;
            end
        end
        return longint'(root);
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint base, z, xs, ys;
        base = 0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            base = (y >= 0) ? 205887 : -205887;
            x = -x;
            y = -y;
        end
        while (labs(x) < (64'sd1 << 40) && labs(y) < (64'sd1 << 40)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_LUT[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_LUT[i];
            end
        end
        return z + base;
    endfunction

    function automatic cmd_result_t control_tick(logic [IN_W-1:0] req);
        longint dx, dz, qw, qx, qy, qz, range_fx, num, den, heading, roll, d, ad, spd, trn;
        longint lin, ang, lw, rw, err, v, half, c;
        logic [65:0] ux, uz;
        logic right;
        cmd_result_t r;
        dx = longint'($signed(req[31:0])) - longint'($signed(req[95:64]));
        dz = longint'($signed(req[63:32])) - longint'($signed(req[127:96]));
        qw = longint'($signed(req[143:128]));
        qx = longint'($signed(req[159:144]));
        qy = longint'($signed(req[175:160]));
        qz = longint'($signed(req[191:176]));
        ux = 66'(labs(dx));
        uz = 66'(labs(dz));
        range_fx = root66(ux * ux + uz * uz);
        num = 2 * (qy * qw - qx * qz);
        den = (64'sd1 << 28) - 2 * qy * qy - 2 * qz * qz;
        heading = vec_angle(dx, dz);
        roll = vec_angle(num, den);
        d = range_fx - stop_rng;
        ad = labs(d);
        spd = (ad > 983040) ? 13107 : ad / 100;
        trn = labs(heading - roll);
        lin = 0; ang = 0; lw = 0; rw = 0;
        r = '0;
        if (spd > spd_cmd) begin
            c = spd_cmd + 1311;
            spd_cmd = spd < c ? spd : c;
        end else if (spd < spd_cmd) begin
            c = spd_cmd - 1311;
            spd_cmd = spd > c ? spd : c;
        end
        if (trn > trn_cmd) begin
            c = trn_cmd + 6554;
            trn_cmd = clip32(trn < c ? trn : c);
        end else if (trn < trn_cmd) begin
            c = trn_cmd - 6554;
            trn_cmd = clip32(trn > c ? trn : c);
        end
        if (heading > 196608 || heading < -196608) heading = 205887;
        err = heading - roll;
        if (err > -ang_tol && err < ang_tol) begin
            if (d < dist_tol && d > -dist_tol) begin
                r.arrived = 1'b1;
                spd_cmd = 0;
                trn_cmd = 0;
                last_lin = 0;
            end else begin
                if (d < 327680) begin
                    if (d > 0) begin
                        lw = 65536; lin = spd_cmd;
                    end else begin
                        lw = -65536; lin = -spd_cmd;
                    end
                end else begin
                    lw = far_spd;
                    lin = spd_cmd;
                end
                rw = lw;
                lin = clip32(lin);
                last_lin = lin;
            end
        end else begin
            v = last_lin;
            half = trn_cmd >>> 1;
            if (labs(v) > 1966) begin
                if (v > 1311) v = v - 655;
                if (v < -1311) v = v + 655;
            end else begin
                v = 0;
            end
            spd_cmd = v;
            last_lin = v;
            lin = v;
            if (heading < -102944 && roll > 102944) right = 1'b0;
            else if (heading > 102944 && roll < -102944) right = 1'b1;
            else right = heading < roll;
            if (right) begin
                lw = half; rw = -half; ang = -trn_cmd;
            end else begin
                lw = -half; rw = half; ang = trn_cmd;
            end
        end
        r.linear   = 32'(clip32(lin));
        r.angular  = 32'(clip32(ang));
        r.left_wh  = 32'(clip32(lw));
        r.right_wh = 32'(clip32(rw));
        return r;
    endfunction

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                cmd_expected.push_back(control_tick(s_tdata));
                void'(tick_queue.pop_front());
                ticks_sent++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= tick_queue[0];
                if (burst_left == 0) begin
                    burst_left = $urandom_range(12);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(60);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off
    int hold_left = 0;
    bit long_hold_done = 0;
    int stall_mode = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!long_hold_done && ticks_sent == 300) begin
            long_hold_done = 1;
            hold_left = 600;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(200) == 0) stall_mode = $urandom_range(2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(3) != 0);
                default: begin
                    if ($urandom_range(9) == 0) begin
                        m_tready <= 1'b0;
                        hold_left = $urandom_range(80);
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // result check
    always @(posedge aclk) begin
        cmd_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.linear   = m_tdata[31:0];
            got.angular  = m_tdata[63:32];
            got.left_wh  = m_tdata[95:64];
            got.right_wh = m_tdata[127:96];
            got.arrived  = m_tdata[128];
            if (cmd_expected.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                want = cmd_expected.pop_front();
                if (got.linear !== want.linear) begin
                    $error("linear_velocity exp %0d got %0d",
                           $signed(want.linear), $signed(got.linear));
                    errors++;
                end
                if (got.angular !== want.angular) begin
                    $error("angular_velocity exp %0d got %0d",
                           $signed(want.angular), $signed(got.angular));
                    errors++;
                end
                if (got.left_wh !== want.left_wh) begin
                    $error("left_wheel exp %0d got %0d",
                           $signed(want.left_wh), $signed(got.left_wh));
                    errors++;
                end
                if (got.right_wh !== want.right_wh) begin
                    $error("right_wheel exp %0d got %0d",
                           $signed(want.right_wh), $signed(got.right_wh));
                    errors++;
                end
                if (got.arrived !== want.arrived) begin
                    $error("arrived exp %0b got %0b", want.arrived, got.arrived);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any request or result moving
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STOP_RANGE: stop_rng = val;
            REG_FAR_SPEED:  far_spd = val;
            REG_ANGLE_TOL:  ang_tol = val[17:0];
            default:        dist_tol = val;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [30:0] sr, logic [30:0] fs, logic [17:0] at, logic [30:0] dt);
        write_reg(REG_STOP_RANGE, sr);
        write_reg(REG_FAR_SPEED, fs);
        write_reg(REG_ANGLE_TOL, {13'd0, at});
        write_reg(REG_DIST_TOL, dt);
    endtask

    function automatic logic [IN_W-1:0] pack_tick(int tx, int tz, int ox, int oz,
                                                  int qw, int qx, int qy, int qz);
        return {qz[15:0], qy[15:0], qx[15:0], qw[15:0], oz, ox, tz, tx};
    endfunction

    function automatic int rand_quat();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    task automatic queue_random(int count);
        int ox, oz, dx, dz, sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(9);
            ox = int'($urandom_range(2097152)) - 1048576;
            oz = int'($urandom_range(2097152)) - 1048576;
            if (sel < 6) begin
                // approach run toward a target near the +z or -z axis, level attitude
                dz = int'($urandom_range(1400000)) - 100000;
                dx = int'($urandom_range(1000)) - 500;
                if (sel == 5) dz = -dz;
                tick_queue.push_back(pack_tick(ox + dx, oz + dz, ox, oz, 16384,
                    int'($urandom_range(200)) - 100, int'($urandom_range(400)) - 200,
                    int'($urandom_range(200)) - 100));
            end else if (sel < 8) begin
                dz = int'($urandom_range(40000000)) - 20000000;
                dx = int'($urandom_range(40000000)) - 20000000;
                tick_queue.push_back(pack_tick(ox + dx, oz + dz, ox, oz,
                    rand_quat(), rand_quat(), rand_quat(), rand_quat()));
            end else begin
                tick_queue.push_back(pack_tick($urandom, $urandom, $urandom, $urandom,
                    rand_quat(), rand_quat(), rand_quat(), rand_quat()));
            end
        end
    endtask

    task automatic drain();
        while (tick_queue.size() > 0 || s_tvalid || cmd_expected.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        stop_rng = 0; far_spd = 196608; ang_tol = 7864; dist_tol = 72090;
        spd_cmd = 0; trn_cmd = 0; last_lin = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed ticks at reset defaults
        tick_queue.push_back(pack_tick(0, 65536, 0, 0, 16384, 0, 0, 0));
        tick_queue.push_back(pack_tick(5, 7, 5, 7, 16384, 0, 0, 0));
        tick_queue.push_back(pack_tick(0, 0, 0, 0, 100, 100, 8192, 8192));
        tick_queue.push_back(pack_tick(0, 4000000, 0, 0, 16384, 0, 0, 0));
        tick_queue.push_back(pack_tick(0, 4000000, 0, 0, 16384, 0, 0, 0));
        tick_queue.push_back(pack_tick(0, 200000, 0, 0, 16384, 0, 0, 0));
        tick_queue.push_back(pack_tick(0, -200000, 0, 0, 0, 0, 16384, 0));
        tick_queue.push_back(pack_tick(0, -200000, 0, 0, 16384, 0, 0, 0));
        tick_queue.push_back(pack_tick(300000, 0, 0, 0, 16384, 0, 0, 0));
        tick_queue.push_back(pack_tick(-300000, 0, 0, 0, 16384, 0, 0, 0));
        tick_queue.push_back(pack_tick(-300000, -10, 0, 0, 11585, 0, 11585, 0));
        tick_queue.push_back(pack_tick(300000, -10, 0, 0, 11585, 0, -11585, 0));
        tick_queue.push_back(pack_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                       16384, 16384, 16384, 16384));
        tick_queue.push_back(pack_tick(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                       -16384, -16384, -16384, -16384));
        tick_queue.push_back(pack_tick(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                       -16384, 16384, -16384, 16384));
        tick_queue.push_back(pack_tick(0, 0, 0, 0, 0, 0, 0, 0));
        tick_queue.push_back(pack_tick(1, 65536, 0, 0, 16384, 0, 0, 0));
        drain();

        set_regs(31'd131072, 31'd98304, 18'd20000, 31'd100000);
        queue_random(480);
        drain();

        set_regs(31'h7FFFFFFF, 31'h7FFFFFFF, 18'd205887, 31'd0);
        queue_random(330);
        drain();

        set_regs(31'd0, 31'd0, 18'd0, 31'h7FFFFFFF);
        queue_random(250);
        drain();

        set_regs(31'd400000, 31'($urandom_range(1000000)), 18'd60000, 31'd200000);
        queue_random(480);
        drain();

        set_regs(31'd0, 31'd196608, 18'd7864, 31'd72090);
        queue_random(350);
        drain();

        if (errors == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/ghsc_pkg.sv
hdl/ghsc_cordic.sv
hdl/ghsc_datapath.sv
hdl/ghsc_ctrl.sv
hdl/goto_heading_speed_controller_core.sv
test/tb_top.sv
